// File: src/ipv4p_pkg.sv
package ipv4p_pkg;

  // ASCII codes that the parser recognizes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Saturation points of the accumulators, the largest legal octet and length, and the last dot count.
  localparam logic [8:0] OCTET_CAP  = 9'd256;
  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [5:0] LENGTH_CAP = 6'd33;
  localparam logic [5:0] MAX_LEN    = 6'd32;
  localparam logic [1:0] LAST_DOT   = 2'd3;

  // Parsing state carried from one character to the next.
  typedef struct packed {
    logic        phase;
    logic [8:0]  octet_value;
    logic [31:0] address_shift;
    logic [1:0]  dot_count;
    logic        previous_was_dot;
    logic [5:0]  length_value;
    logic        length_digits_seen;
    logic        error_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:              1'b0,
    octet_value:        9'd0,
    address_shift:      32'd0,
    dot_count:          2'd0,
    previous_was_dot:   1'b1,
    length_value:       6'd0,
    length_digits_seen: 1'b0,
    error_seen:         1'b0
  };

  // Netmask with the top len bits set; a length of zero gives no bits.
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    prefix_mask = ~(32'hFFFF_FFFF >> len);
  endfunction

endpackage

// File: src/ipv4p_if.sv
interface ipv4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ipv4p_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;
  logic [31:0] netmask;
  logic [5:0]  prefix_length;

  modport source (output valid, output ok, output address, output netmask,
                  output prefix_length, input ready);
  modport sink   (input valid, input ok, input address, input netmask,
                  input prefix_length, output ready);
endinterface

// File: src/ipv4p_step.sv
module ipv4p_step (
  input  ipv4p_pkg::parse_state_t cur,
  input  logic [7:0]              char_code,
  output ipv4p_pkg::parse_state_t nxt
);

  logic        is_digit;
  logic [3:0]  digit_value;
  logic [11:0] octet_sum;
  logic [8:0]  length_sum;

  assign is_digit    = (char_code >= ipv4p_pkg::CHAR_ZERO) &&
                       (char_code <= ipv4p_pkg::CHAR_NINE);
  assign digit_value = 4'(char_code - ipv4p_pkg::CHAR_ZERO);
  assign octet_sum   = 12'(cur.octet_value) * 12'd10 + 12'(digit_value);
  assign length_sum  = 9'(cur.length_value) * 9'd10 + 9'(digit_value);

  // One character of the prefix string advances the parse state.
  always_comb begin
    nxt = cur;
    if (!cur.error_seen) begin
      if (!cur.phase) begin
        priority if (is_digit) begin
          nxt.octet_value = (octet_sum > 12'(ipv4p_pkg::OCTET_CAP)) ?
                            ipv4p_pkg::OCTET_CAP : octet_sum[8:0];
          nxt.previous_was_dot = 1'b0;
        end else if (char_code == ipv4p_pkg::CHAR_DOT) begin
          if (cur.previous_was_dot || cur.dot_count == ipv4p_pkg::LAST_DOT ||
              cur.octet_value > ipv4p_pkg::OCTET_MAX) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.address_shift    = {cur.address_shift[23:0], cur.octet_value[7:0]};
            nxt.dot_count        = cur.dot_count + 2'd1;
            nxt.octet_value      = 9'd0;
            nxt.previous_was_dot = 1'b1;
          end
        end else if (char_code == ipv4p_pkg::CHAR_SLASH) begin
          if (cur.previous_was_dot || cur.dot_count != ipv4p_pkg::LAST_DOT ||
              cur.octet_value > ipv4p_pkg::OCTET_MAX) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.address_shift = {cur.address_shift[23:0], cur.octet_value[7:0]};
            nxt.octet_value   = 9'd0;
            nxt.phase         = 1'b1;
          end
        end else begin
          nxt.error_seen = 1'b1;
        end
      end else begin
        // After the slash only digits of the length are legal.
        if (is_digit) begin
          nxt.length_value = (length_sum > 9'(ipv4p_pkg::LENGTH_CAP)) ?
                             ipv4p_pkg::LENGTH_CAP : length_sum[5:0];
          nxt.length_digits_seen = 1'b1;
        end else begin
          nxt.error_seen = 1'b1;
        end
      end
    end
  end

endmodule

// File: src/ipv4_prefix_text_parser.sv
// Channel   Dir  Role    Payload
// chars     in   sink    char_code[7:0], is_last
// result    out  source  ok, address[31:0], netmask[31:0], prefix_length[5:0]
//
// One character is taken per cycle while chars.ready is high; the parse state updates in that cycle.
// The result appears in the output register in the cycle after the last character is taken.
// A stalled result holds chars.ready low only until it is taken; while the
// result is being taken in the same cycle a new character is still accepted.
// rst is synchronous and active high; it empties the result register and
// returns the parse state to the start of a string.
module ipv4_prefix_text_parser (
  input  logic              clk,
  input  logic              rst,
  ipv4p_in_if.sink          chars,
  ipv4p_out_if.source       result
);

  ipv4p_pkg::parse_state_t st;
  ipv4p_pkg::parse_state_t st_next;
  logic                    accept;
  logic                    final_ok;

  assign chars.ready = !result.valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  ipv4p_step u_step (
    .cur       (st),
    .char_code (chars.char_code),
    .nxt       (st_next)
  );

  assign final_ok = !st_next.error_seen && st_next.phase &&
                    st_next.length_digits_seen &&
                    (st_next.length_value <= ipv4p_pkg::MAX_LEN);

  // Parse state: advance on each character, restart after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ipv4p_pkg::STATE_RESET;
    end else if (accept) begin
      st <= chars.is_last ? ipv4p_pkg::STATE_RESET : st_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && chars.is_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result payload, zeroed on rejection.
  always_ff @(posedge clk) begin
    if (accept && chars.is_last) begin
      result.ok            <= final_ok;
      result.address       <= final_ok ? st_next.address_shift : 32'd0;
      result.netmask       <= final_ok ?
                              ipv4p_pkg::prefix_mask(st_next.length_value) : 32'd0;
      result.prefix_length <= final_ok ? st_next.length_value : 6'd0;
    end
  end

  // A character without the last mark never raises a result.
  assert property (@(posedge clk) disable iff (rst)
    accept && !chars.is_last |=> !$rose(result.valid))
    else $error("result raised by a non-final character");

  // The parse state restarts after the last character.
  assert property (@(posedge clk) disable iff (rst)
    accept && chars.is_last |=> (st == ipv4p_pkg::STATE_RESET))
    else $error("parse state not restarted after a string");

  // A rejected string carries an all-zero payload.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ok |->
      (result.address == 32'd0) && (result.netmask == 32'd0) &&
      (result.prefix_length == 6'd0))
    else $error("rejected result with nonzero payload");

  // An accepted string has a legal length and the matching netmask.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ok |->
      (result.prefix_length <= ipv4p_pkg::MAX_LEN) &&
      (result.netmask == ipv4p_pkg::prefix_mask(result.prefix_length)))
    else $error("accepted result with bad length or netmask");

endmodule

// File: verif/ipv4_prefix_text_parser_test.sv
`timescale 1ns / 1ps

module ipv4_prefix_text_parser_test;

  typedef logic [7:0] text_t[$];

  // One parsed prefix as it leaves the block.
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [5:0]  prefix_length;
  } prefix_result_t;

  // Tracks the parse of the current string and holds the prefixes still owed by the block.
  class prefix_board;
    bit             in_length;
    logic [8:0]     octet_acc;
    logic [31:0]    packed_addr;
    logic [1:0]     dots;
    bit             after_dot;
    logic [5:0]     len_acc;
    bit             len_digit;
    bit             failed;
    prefix_result_t owed_prefixes[$];
    int             mismatches;
    int             checked;
    int             good_prefixes;

    function new();
      clear_parse();
      mismatches    = 0;
      checked       = 0;
      good_prefixes = 0;
    endfunction

    function void clear_parse();
      in_length   = 1'b0;
      octet_acc   = '0;
      packed_addr = '0;
      dots        = '0;
      after_dot   = 1'b1;
      len_acc     = '0;
      len_digit   = 1'b0;
      failed      = 1'b0;
    endfunction

    function int pending();
      return owed_prefixes.size();
    endfunction

    // Advance the parse by one accepted character and, on the last one, record the prefix owed.
    function void note_char(logic [7:0] c, logic last);
      int             v;
      bit             digit;
      prefix_result_t want;
      digit = (c >= ipv4p_pkg::CHAR_ZERO) && (c <= ipv4p_pkg::CHAR_NINE);
      if (!failed) begin
        if (!in_length) begin
          if (digit) begin
            v = int'(octet_acc) * 10 + int'(c - ipv4p_pkg::CHAR_ZERO);
            octet_acc = (v > 256) ? 9'd256 : 9'(v);
            after_dot = 1'b0;
          end else if (c == ipv4p_pkg::CHAR_DOT) begin
            if (after_dot || dots == ipv4p_pkg::LAST_DOT || octet_acc > 9'd255) begin
              failed = 1'b1;
            end else begin
              packed_addr = {packed_addr[23:0], octet_acc[7:0]};
              dots        = dots + 2'd1;
              octet_acc   = '0;
              after_dot   = 1'b1;
            end
          end else if (c == ipv4p_pkg::CHAR_SLASH) begin
            if (after_dot || dots != ipv4p_pkg::LAST_DOT || octet_acc > 9'd255) begin
              failed = 1'b1;
            end else begin
              packed_addr = {packed_addr[23:0], octet_acc[7:0]};
              octet_acc   = '0;
              in_length   = 1'b1;
            end
          end else begin
            failed = 1'b1;
          end
        end else if (digit) begin
          v = int'(len_acc) * 10 + int'(c - ipv4p_pkg::CHAR_ZERO);
          len_acc   = (v > 33) ? 6'd33 : 6'(v);
          len_digit = 1'b1;
        end else begin
          failed = 1'b1;
        end
      end
      if (last) begin
        want = '0;
        if (!failed && in_length && len_digit && len_acc <= 6'd32) begin
          want.ok            = 1'b1;
          want.address       = packed_addr;
          want.prefix_length = len_acc;
          // A shift by the full width leaves no bits, which is the zero-length mask.
          want.netmask       = 32'hFFFF_FFFF << (32 - int'(len_acc));
        end
        owed_prefixes.push_back(want);
        clear_parse();
      end
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%t mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
    endfunction

    // Compare one delivered prefix with the oldest one owed.
    function void check_prefix(prefix_result_t got);
      prefix_result_t want;
      if (owed_prefixes.size() == 0) begin
        report("unexpected result (ok flag)", 32'd0, 32'(got.ok));
        return;
      end
      want = owed_prefixes.pop_front();
      checked++;
      if (want.ok)
        good_prefixes++;
      if (got.ok !== want.ok)
        report("ok", 32'(want.ok), 32'(got.ok));
      if (got.address !== want.address)
        report("address", want.address, got.address);
      if (got.netmask !== want.netmask)
        report("netmask", want.netmask, got.netmask);
      if (got.prefix_length !== want.prefix_length)
        report("prefix_length", 32'(want.prefix_length), 32'(got.prefix_length));
    endfunction
  endclass

  logic clk;
  logic rst;

  ipv4p_in_if  chars_bus();
  ipv4p_out_if result_bus();

  ipv4_prefix_text_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .result (result_bus)
  );

  prefix_board board = new();

  int chars_sent   = 0;
  int strings_sent = 0;
  int gap_odds     = 0;
  int stall_odds   = 0;
  int stall_left   = 0;
  bit calm         = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watch both channels and feed every handshake to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (chars_bus.valid && chars_bus.ready)
        board.note_char(chars_bus.char_code, chars_bus.is_last);
      if (result_bus.valid && result_bus.ready)
        board.check_prefix({result_bus.ok, result_bus.address, result_bus.netmask,
                            result_bus.prefix_length});
    end
  end

  // The receiver stalls in random bursts unless the run is in a quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left       <= stall_left - 1;
    end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
      result_bus.ready <= 1'b0;
      stall_left       <= $urandom_range(0, 16);
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // Present one character, maybe after an idle burst, and hold it until it is taken.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      gap = $urandom_range(1, 17);
      chars_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_bus.valid     <= 1'b1;
    chars_bus.char_code <= c;
    chars_bus.is_last   <= last;
    @(posedge clk);
    while (!chars_bus.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i])
      send_char(t[i], i == t.size() - 1);
    strings_sent++;
  endtask

  function automatic text_t to_text(string s);
    text_t t;
    foreach (s[i])
      t.push_back(s[i]);
    return t;
  endfunction

  // Decimal digits of a value, sometimes with leading zeros.
  function automatic text_t decimal(int v);
    text_t t;
    int    pad;
    pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    repeat (pad) t.push_back(ipv4p_pkg::CHAR_ZERO);
    t = {t, to_text($sformatf("%0d", v))};
    return t;
  endfunction

  // Characters biased toward the ones the parser cares about.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return ipv4p_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    else if (r == 5)
      return ipv4p_pkg::CHAR_DOT;
    else if (r == 6)
      return ipv4p_pkg::CHAR_SLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  // A well-formed prefix with random content; now and then an octet or the length is too big.
  function automatic text_t prefix_text();
    text_t t;
    int    r;
    for (int k = 0; k < 4; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        t = {t, decimal(0)};
      else if (r == 1)
        t = {t, decimal(255)};
      else if (r == 2)
        t = {t, decimal($urandom_range(256, 99999))};
      else
        t = {t, decimal($urandom_range(0, 255))};
      t.push_back((k == 3) ? ipv4p_pkg::CHAR_SLASH : ipv4p_pkg::CHAR_DOT);
    end
    r = $urandom_range(0, 15);
    if (r == 0)
      t = {t, decimal(0)};
    else if (r == 1)
      t = {t, decimal(32)};
    else if (r == 2)
      t = {t, decimal($urandom_range(33, 99999))};
    else
      t = {t, decimal($urandom_range(0, 32))};
    return t;
  endfunction

  // Break a string by replacing, inserting or dropping one character.
  function automatic text_t mutate(input text_t t);
    int pos;
    pos = $urandom_range(0, t.size() - 1);
    case ($urandom_range(0, 2))
      0: begin
        t[pos] = pick_char();
      end
      1: begin
        t.insert(pos, pick_char());
      end
      default: begin
        if (t.size() > 1)
          t.delete(pos);
      end
    endcase
    return t;
  endfunction

  function automatic text_t noise_text();
    text_t t;
    repeat ($urandom_range(1, 12)) t.push_back(pick_char());
    return t;
  endfunction

  initial begin
    string directed[$];
    text_t t;
    int    kind;
    int    drain;
    bit    paused;

    directed = '{"0.0.0.0/0", "255.255.255.255/32", "10.1.2.3/8", "001.02.3.004/024",
                 "1.2.3.4a/8", "1..2.3/8", ".1.2.3/8", "1.2.3.4.5/8", "1.2.3/8",
                 "1.2.3./8", "256.1.1.1/8", "99999.1.1.1/1", "1.2.3.4", "1.2.3.4/",
                 "1.2.3.4/33", "1.2.3.4/999", "1.2.3.4/1/2", "1.2.3.4/x", "/", "7"};
    paused = 1'b0;

    rst                 = 1'b1;
    chars_bus.valid     = 1'b0;
    chars_bus.char_code = '0;
    chars_bus.is_last   = 1'b0;
    result_bus.ready    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed strings, including the top bit and a NUL byte on a single character.
    foreach (directed[i])
      send_text(to_text(directed[i]));
    t = '{8'hFF};
    send_text(t);
    t = '{8'h00};
    send_text(t);
    t = to_text("1.2.3.4/5");
    t[2] = 8'h80;
    send_text(t);

    // Random strings, mostly well formed, under changing idle patterns.
    while (chars_sent < 1800) begin
      if (strings_sent % 20 == 0) begin
        gap_odds   = $urandom_range(0, 2) * 4;
        stall_odds = $urandom_range(0, 2) * 4;
      end
      if (chars_sent > 1500)
        calm = 1'b1;
      if (!paused && chars_sent >= 900) begin
        // Let the block drain completely before carrying on.
        chars_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        paused = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 14)
        send_text(prefix_text());
      else if (kind < 17)
        send_text(mutate(prefix_text()));
      else
        send_text(noise_text());
    end
    chars_bus.valid <= 1'b0;
    @(posedge clk);

    // Drain the outstanding prefixes, then give the output register time to settle.
    drain = 0;
    while (board.pending() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (board.pending() != 0)
      board.report("prefixes never delivered (count)", 32'd0, 32'(board.pending()));

    $display("Drove %0d characters in %0d strings; %0d prefixes checked, %0d of them valid.",
             chars_sent, strings_sent, board.checked, board.good_prefixes);
    $display("Mismatches: %0d.", board.mismatches);
    if (board.mismatches == 0)
      $display("ipv4_prefix_text_parser_test: done, clean");
    else
      $display("ipv4_prefix_text_parser_test: done, errors");
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20_000_000;
    $display("Timed out after %0d characters.", chars_sent);
    $display("ipv4_prefix_text_parser_test: done, errors");
    $finish;
  end

endmodule
